[rtl/core/fmmc_pkg.sv]
// shared constants and types of the fast modulo magic number calculator
package fmmc_pkg;

  localparam int unsigned DIVISOR_BITS    = 32;
  localparam int unsigned IN_TDATA_BITS   = 32;
  localparam int unsigned RECIP_BITS      = 32;
  localparam int unsigned SHIFT_BITS      = 6;
  localparam int unsigned OUT_TDATA_BITS  = 40;
  localparam int unsigned OUT_TUSER_BITS  = 1;
  localparam int unsigned OUT_PAD_BITS    = OUT_TDATA_BITS - RECIP_BITS - 1 - SHIFT_BITS;
  localparam int unsigned LOG_BITS        = $clog2(DIVISOR_BITS);
  localparam int unsigned CNT_BITS        = $clog2(DIVISOR_BITS + 1);
  localparam int unsigned STEPS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES      =
      (DIVISOR_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  localparam logic [DIVISOR_BITS:0] REM_INIT =
      (DIVISOR_BITS + 1)'(1) << (DIVISOR_BITS - 1);

  typedef struct packed {
    logic                bad;
    logic                pow2;
    logic [LOG_BITS-1:0] lg;
  } meta_t;

  typedef struct packed {
    meta_t                 meta;
    logic [CNT_BITS-1:0]   cnt;
    logic [DIVISOR_BITS-1:0] dn;
    logic [DIVISOR_BITS:0] rem;
    logic [DIVISOR_BITS-1:0] quo;
  } div_t;

endpackage

[rtl/core/fast_mod_magic_calc_core.sv]
// top level of the magic number calculator for division by an invariant divisor
//
// the slave channel takes one divisor per item in s_axis_tdata_i; only its low
// DIVISOR_BITS bits are used. the master channel gives one result item per
// divisor, in order: reciprocal, increment and shift in m_axis_tdata_o, and
// the zero divisor flag in m_axis_tuser_o.
// the pipeline has two front stages for the leading one search and
// normalization, DIV_STAGES divider stages of four quotient bits each, and
// the output register.
// throughput is one item per cycle while the receiver takes results; the
// divider stage count sets the latency, not the rate.
// every stage has its own valid bit and ready, so bubbles close up and an item
// is taken while an earlier result still waits at the output.
// when the receiver stalls, items fill the stages and s_axis_tready_o drops
// once all are full; nothing is dropped or repeated.
// reset clears all valid bits; no result is pending after reset.
module fast_mod_magic_calc_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [31:0] divisor
  input  logic [fmmc_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [31:0] reciprocal, [32] increment, [38:33] shift, [39] zero pad
  output logic [fmmc_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata_o,
  // [0] bad_divisor
  output logic [fmmc_pkg::OUT_TUSER_BITS-1:0]  m_axis_tuser_o
);

  logic           stg_valid [fmmc_pkg::DIV_STAGES+1];
  logic           stg_ready [fmmc_pkg::DIV_STAGES+1];
  fmmc_pkg::div_t stg_data  [fmmc_pkg::DIV_STAGES+1];

  fmmc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .data_o  (stg_data[0])
  );

  for (genvar g = 0; g < int'(fmmc_pkg::DIV_STAGES); g++) begin : g_div
    fmmc_div_stage u_div_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .ready_o (stg_ready[g]),
      .data_i  (stg_data[g]),
      .valid_o (stg_valid[g+1]),
      .ready_i (stg_ready[g+1]),
      .data_o  (stg_data[g+1])
    );
  end

  fmmc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid[fmmc_pkg::DIV_STAGES]),
    .ready_o (stg_ready[fmmc_pkg::DIV_STAGES]),
    .data_i  (stg_data[fmmc_pkg::DIV_STAGES]),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o),
    .user_o  (m_axis_tuser_o)
  );

`ifndef SYNTHESIS
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("zero divisor result carries nonzero data");

  a_recip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[31:0] != '0)
    else $error("valid divisor gave zero reciprocal");

  a_inc_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[32]
      |-> m_axis_tdata_o[38:33] >= fmmc_pkg::SHIFT_BITS'(fmmc_pkg::DIVISOR_BITS))
    else $error("increment set with a power of two shift");

  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid[fmmc_pkg::DIV_STAGES]
      |-> stg_data[fmmc_pkg::DIV_STAGES].cnt
          == fmmc_pkg::CNT_BITS'(fmmc_pkg::DIVISOR_BITS))
    else $error("divider item left with quotient bits missing");
`endif

endmodule

[rtl/core/fmmc_front.sv]
// front stages: divisor classification, leading one search and normalization
module fmmc_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic [fmmc_pkg::IN_TDATA_BITS-1:0]   data_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output fmmc_pkg::div_t                       data_o
);

  logic [fmmc_pkg::DIVISOR_BITS-1:0] d;
  logic [fmmc_pkg::LOG_BITS-1:0]     lg;
  fmmc_pkg::meta_t                   meta1_d;

  logic                              vld1_q;
  logic [fmmc_pkg::DIVISOR_BITS-1:0] d1_q;
  fmmc_pkg::meta_t                   meta1_q;
  logic                              rdy1;

  fmmc_pkg::div_t                    div2_d;
  fmmc_pkg::div_t                    div2_q;
  logic                              vld2_q;
  logic                              rdy2;

  // stage 1: mask, zero and power of two detect, floor log2
  always_comb begin
    d  = data_i[fmmc_pkg::DIVISOR_BITS-1:0];
    lg = '0;
    for (int i = 0; i < int'(fmmc_pkg::DIVISOR_BITS); i++) begin
      if (d[i]) begin
        lg = fmmc_pkg::LOG_BITS'(i);
      end
    end
    meta1_d.bad  = (d == '0);
    meta1_d.pow2 = ((d & (d - fmmc_pkg::DIVISOR_BITS'(1))) == '0);
    meta1_d.lg   = lg;
  end

  assign rdy1    = !vld1_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (rdy1) begin
      vld1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy1) begin
      d1_q    <= d;
      meta1_q <= meta1_d;
    end
  end

  // stage 2: left align the divisor so its top bit is set
  always_comb begin
    div2_d.meta = meta1_q;
    div2_d.cnt  = '0;
    div2_d.dn   = d1_q << (fmmc_pkg::LOG_BITS'(fmmc_pkg::DIVISOR_BITS - 1) - meta1_q.lg);
    div2_d.rem  = fmmc_pkg::REM_INIT;
    div2_d.quo  = '0;
  end

  assign rdy2 = !vld2_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (rdy2) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld1_q && rdy2) begin
      div2_q <= div2_d;
    end
  end

  assign valid_o = vld2_q;
  assign data_o  = div2_q;

endmodule

[rtl/core/fmmc_div_stage.sv]
// one registered stage of the restoring divider, STEPS_PER_STAGE (four) quotient bits per stage
module fmmc_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  fmmc_pkg::div_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output fmmc_pkg::div_t data_o
);

  fmmc_pkg::div_t                    w;
  logic [fmmc_pkg::DIVISOR_BITS:0]   trial;
  logic [fmmc_pkg::DIVISOR_BITS:0]   dn_ext;
  fmmc_pkg::div_t                    div_q;
  logic                              vld_q;

  always_comb begin
    w      = data_i;
    trial  = '0;
    dn_ext = {1'b0, data_i.dn};
    for (int k = 0; k < int'(fmmc_pkg::STEPS_PER_STAGE); k++) begin
      if (w.cnt < fmmc_pkg::CNT_BITS'(fmmc_pkg::DIVISOR_BITS)) begin
        trial = {w.rem[fmmc_pkg::DIVISOR_BITS-1:0], 1'b0};
        if (trial >= dn_ext) begin
          w.rem = trial - dn_ext;
          w.quo = {w.quo[fmmc_pkg::DIVISOR_BITS-2:0], 1'b1};
        end else begin
          w.rem = trial;
          w.quo = {w.quo[fmmc_pkg::DIVISOR_BITS-2:0], 1'b0};
        end
        w.cnt = w.cnt + fmmc_pkg::CNT_BITS'(1);
      end
    end
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      div_q <= w;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = div_q;

endmodule

[rtl/core/fmmc_back.sv]
// final stage: rounding choice, special divisors and output register
module fmmc_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  fmmc_pkg::div_t                       data_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic [fmmc_pkg::OUT_TDATA_BITS-1:0]  data_o,
  output logic [fmmc_pkg::OUT_TUSER_BITS-1:0]  user_o
);

  logic [fmmc_pkg::DIVISOR_BITS-1:0]   recip;
  logic                                inc;
  logic [fmmc_pkg::SHIFT_BITS-1:0]     shift;
  logic                                round_down;
  logic [fmmc_pkg::OUT_TDATA_BITS-1:0] data_d;
  logic [fmmc_pkg::OUT_TDATA_BITS-1:0] data_q;
  logic [fmmc_pkg::OUT_TUSER_BITS-1:0] user_d;
  logic [fmmc_pkg::OUT_TUSER_BITS-1:0] user_q;
  logic                                vld_q;

  always_comb begin
    round_down = ((fmmc_pkg::DIVISOR_BITS + 2)'(data_i.rem) << 1)
                 < (fmmc_pkg::DIVISOR_BITS + 2)'(data_i.dn);
    if (data_i.meta.bad) begin
      recip = '0;
      inc   = 1'b0;
      shift = '0;
    end else if (data_i.meta.pow2) begin
      recip = fmmc_pkg::DIVISOR_BITS'(1);
      inc   = 1'b0;
      shift = fmmc_pkg::SHIFT_BITS'(data_i.meta.lg);
    end else begin
      shift = fmmc_pkg::SHIFT_BITS'(fmmc_pkg::DIVISOR_BITS)
              + fmmc_pkg::SHIFT_BITS'(data_i.meta.lg);
      if (round_down) begin
        recip = data_i.quo;
        inc   = 1'b1;
      end else begin
        recip = data_i.quo + fmmc_pkg::DIVISOR_BITS'(1);
        inc   = 1'b0;
      end
    end
    data_d = {{fmmc_pkg::OUT_PAD_BITS{1'b0}}, shift, inc,
              fmmc_pkg::RECIP_BITS'(recip)};
    user_d = fmmc_pkg::OUT_TUSER_BITS'(data_i.meta.bad);
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
      user_q <= user_d;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = data_q;
  assign user_o  = user_q;

endmodule
